// ===== hw/rtl/ffc_pkg.sv =====
// Package for the float to fixed-point converter: widths and helper constants.
// Depends on nothing; imported by the converter top, its checker and its testbench.
`default_nettype none
package ffc_pkg;
  localparam int ValueW  = 32;
  localparam int FmtW    = 4;
  localparam int FixedW  = 31;
  localparam int MantW   = 24;
  localparam int ShiftW  = 10;
  localparam logic [7:0] ExpoSpecial = 8'hFF;
  localparam int ExpoBias = 150;
  localparam int ShiftMaxLeft = 39;
endpackage
`default_nettype wire

// ===== hw/rtl/float_to_fixed_format_convert_top.sv =====
// Top level of the float to fixed-point converter, a four-stage pipeline.
// Depends on ffc_pkg.
`default_nettype none
//
//  channel | ports                                            | handshake
//  --------+--------------------------------------------------+---------------------------
//  input   | in_value_bits, in_int_width, in_frac_width,       | start & !busy
//          | in_signed_format                                 |
//  result  | out_fixed_value, out_out_of_range                | done, one cycle, no stall
//
// One request enters every cycle; its result shows on done once it leaves the last stage.
// The path is set by the stages: decode/shift amount, barrel shift, range check,
// negate and mask. busy is always low since the receiver cannot stall.
// Reset clears only the valid bits of the stages.
module float_to_fixed_format_convert_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [ffc_pkg::ValueW-1:0]     in_value_bits,
  input  wire logic [ffc_pkg::FmtW-1:0]       in_int_width,
  input  wire logic [ffc_pkg::FmtW-1:0]       in_frac_width,
  input  wire logic                           in_signed_format,
  output logic                                done,
  output logic [ffc_pkg::FixedW-1:0]          out_fixed_value,
  output logic                                out_out_of_range
);
  import ffc_pkg::*;

  typedef struct packed {
    logic              nan;
    logic              neg;
    logic              sf;
    logic [4:0]        n;
  } ctl_t;

  // stage 1: decode
  logic                 v1_r;
  ctl_t                 c1_r;
  logic [MantW-1:0]     mant1_r;
  logic signed [ShiftW-1:0] sh1_r;
  // stage 2: shift
  logic                 v2_r;
  ctl_t                 c2_r;
  logic [63:0]          full2_r;
  logic                 far2_r;
  // stage 3: range
  logic                 v3_r;
  ctl_t                 c3_r;
  logic [29:0]          mag3_r;
  logic                 over3_r;
  // stage 4: output
  logic                 v4_r;
  logic [FixedW-1:0]    res4_r;
  logic                 over4_r;

  logic [7:0]           expo;
  logic [MantW-1:0]     mant_nxt;
  logic signed [ShiftW-1:0] sh_nxt;
  ctl_t                 c_nxt;
  logic [63:0]          full_nxt;
  logic                 far_nxt;
  logic [29:0]          mask3;
  logic [29:0]          mag_nxt;
  logic                 over_nxt;
  logic [29:0]          mask4;
  logic [29:0]          neg4;
  logic [FixedW-1:0]    res_nxt;

  assign busy = 1'b0;

  always_comb begin
    expo = in_value_bits[30:23];
    if (expo == 8'd0) begin
      mant_nxt = {1'b0, in_value_bits[22:0]};
      sh_nxt   = ShiftW'(-149) + ShiftW'(in_frac_width);
    end else begin
      mant_nxt = {1'b1, in_value_bits[22:0]};
      sh_nxt   = ShiftW'(expo) - ShiftW'(ExpoBias) + ShiftW'(in_frac_width);
    end
    c_nxt.nan = (expo == ExpoSpecial);
    c_nxt.neg = in_value_bits[31] && (mant_nxt != '0);
    c_nxt.sf  = in_signed_format;
    c_nxt.n   = 5'(in_int_width) + 5'(in_frac_width);
  end

  always_comb begin
    full_nxt = '0;
    far_nxt  = 1'b0;
    if (sh1_r < 0) begin
      // right shift; anything past 31 leaves zero
      if (-sh1_r < ShiftW'(32)) full_nxt = 64'(mant1_r >> 5'(-sh1_r));
    end else if (sh1_r <= ShiftW'(ShiftMaxLeft)) begin
      full_nxt = 64'(mant1_r) << 6'(sh1_r);
    end else begin
      far_nxt = (mant1_r != '0);
    end
  end

  always_comb begin
    mask3    = 30'((31'd1 << c2_r.n) - 31'd1);
    mag_nxt  = full2_r[29:0] & mask3;
    over_nxt = far2_r || ((full2_r >> c2_r.n) != 64'd0);
  end

  always_comb begin
    mask4 = 30'((31'd1 << c3_r.n) - 31'd1);
    neg4  = (30'd0 - mag3_r) & mask4;
    if (c3_r.nan) begin
      res_nxt = '0;
    end else if (c3_r.neg) begin
      res_nxt = {1'b0, neg4};
      if (neg4 != '0 && c3_r.sf) res_nxt = res_nxt | (FixedW'(1) << c3_r.n);
    end else begin
      res_nxt = {1'b0, mag3_r};
    end
  end

  // valid bits: advance every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    c1_r    <= c_nxt;
    mant1_r <= mant_nxt;
    sh1_r   <= sh_nxt;
    c2_r    <= c1_r;
    full2_r <= full_nxt;
    far2_r  <= far_nxt;
    c3_r    <= c2_r;
    mag3_r  <= mag_nxt;
    over3_r <= over_nxt || c2_r.nan;
    res4_r  <= res_nxt;
    over4_r <= over3_r;
  end

  assign done             = v4_r;
  assign out_fixed_value  = res4_r;
  assign out_out_of_range = over4_r;

`ifndef SYNTH
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##4 done) else $error("result lost");
  a_nan: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && c3_r.nan |=> out_out_of_range && out_fixed_value == '0)
    else $error("special value not flagged");
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !c3_r.neg |=> out_fixed_value[FixedW-1] == 1'b0)
    else $error("top bit set");
`endif
endmodule
`default_nettype wire

// ===== dv/float_to_fixed_format_convert_checker.sv =====
// Checker for the float to fixed-point converter: watches requests and results,
// predicts each conversion and compares it. Depends on ffc_pkg.
module float_to_fixed_format_convert_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [ffc_pkg::ValueW-1:0] in_value_bits,
  input  logic [ffc_pkg::FmtW-1:0]   in_int_width,
  input  logic [ffc_pkg::FmtW-1:0]   in_frac_width,
  input  logic                       in_signed_format,
  input  logic                       done,
  input  logic [ffc_pkg::FixedW-1:0] out_fixed_value,
  input  logic                       out_out_of_range,
  output int                         fail_count,
  output int                         pending_count
);
  import ffc_pkg::*;

  typedef struct packed {
    logic [FixedW-1:0] fixed;
    logic              oor;
  } conv_t;

  conv_t conv_q[$];

  function automatic conv_t convert(logic [31:0] bits, logic [3:0] iw, logic [3:0] fw,
                                    logic sf);
    conv_t r;
    int unsigned n;
    logic [31:0] mant, mask, mag, res;
    logic [63:0] full;
    int sh;
    n = iw + fw;
    mask = (32'd1 << n) - 1;
    r = '0;
    if (bits[30:23] == ExpoSpecial) begin
      r.oor = 1'b1;
      return r;
    end
    if (bits[30:23] == 8'd0) begin
      mant = {9'd0, bits[22:0]};
      sh = -149 + int'(fw);
    end else begin
      mant = {8'd0, 1'b1, bits[22:0]};
      sh = int'(bits[30:23]) - ExpoBias + int'(fw);
    end
    mag = 0;
    if (mant != 0) begin
      if (sh > ShiftMaxLeft) begin
        r.oor = 1'b1;
      end else begin
        if (sh < 0) full = (-sh >= 32) ? 64'd0 : 64'(mant >> (-sh));
        else full = 64'(mant) << sh;
        if (full >= (64'd1 << n)) r.oor = 1'b1;
        mag = full[31:0] & mask;
      end
    end
    if (bits[31] && mant != 0) begin
      res = (32'd0 - mag) & mask;
      if (res != 0 && sf) res |= 32'd1 << n;
    end else begin
      res = mag;
    end
    r.fixed = res[FixedW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    conv_t exp_r;
    if (rst_n && done) begin
      if (conv_q.size() == 0) begin
        report_mismatch("result with no request waiting");
      end else begin
        exp_r = conv_q.pop_front();
        if (out_fixed_value !== exp_r.fixed)
          report_mismatch($sformatf("fixed_value %h, expected %h", out_fixed_value,
                                    exp_r.fixed));
        if (out_out_of_range !== exp_r.oor)
          report_mismatch($sformatf("out_of_range %b, expected %b", out_out_of_range,
                                    exp_r.oor));
      end
    end
    if (rst_n && start && !busy)
      conv_q.push_back(convert(in_value_bits, in_int_width, in_frac_width,
                               in_signed_format));
    pending_count = conv_q.size();
  end
endmodule

// ===== dv/float_to_fixed_format_convert_top_test.sv =====
// Top of the converter testbench: clock, reset, directed and random requests,
// and the verdict. Depends on ffc_pkg, float_to_fixed_format_convert_top and the checker.
module float_to_fixed_format_convert_top_test;
  import ffc_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [ValueW-1:0] in_value_bits;
  logic [FmtW-1:0]   in_int_width;
  logic [FmtW-1:0]   in_frac_width;
  logic              in_signed_format;
  logic              done;
  logic [FixedW-1:0] out_fixed_value;
  logic              out_out_of_range;
  int                fail_count;
  int                pending_count;
  int                cycle_count;

  localparam int NumRandom  = 2000;
  localparam int DrainWait  = 20;
  // Worst case: every request waits its longest gap plus its own, then pipeline drain.
  localparam int CycleLimit = 200000;

  float_to_fixed_format_convert_top u_top (
    .clk, .rst_n, .start, .busy, .in_value_bits, .in_int_width, .in_frac_width,
    .in_signed_format, .done, .out_fixed_value, .out_out_of_range
  );

  float_to_fixed_format_convert_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_value_bits, .in_int_width, .in_frac_width,
    .in_signed_format, .done, .out_fixed_value, .out_out_of_range, .fail_count,
    .pending_count
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: end the run if it hangs.
  initial begin
    clk = 1'b0;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Send one request: hold start until accepted, then drop it unless the next
  // request follows with no gap (so start is never lowered and raised in a step).
  task automatic send_request(logic [31:0] bits, logic [3:0] iw, logic [3:0] fw, logic sf,
                              int gap);
    start            <= 1'b1;
    in_value_bits    <= bits;
    in_int_width     <= iw;
    in_frac_width    <= fw;
    in_signed_format <= sf;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Draw a float pattern biased toward exponents that land near the formats.
  function automatic logic [31:0] rand_float();
    logic [31:0] b;
    b = $urandom;
    case ($urandom_range(0, 9))
      0:       b[30:23] = 8'hFF;
      1:       b[30:23] = 8'h00;
      2:       b[30:23] = 8'($urandom_range(0, 255));
      default: b[30:23] = 8'($urandom_range(110, 150));
    endcase
    return b;
  endfunction

  function automatic int rand_gap();
    // Stretches of back-to-back requests as well as idle gaps.
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
  endfunction

  logic [31:0] directed_vals[] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000,
    32'hFF80_0000, 32'h7FC0_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
    32'hFF7F_FFFF, 32'h3F00_0000, 32'hBEFF_FFFF, 32'h4700_0000, 32'hC6FF_FE00,
    32'h4EFF_FFFF, 32'hBF40_0000, 32'h4F00_0000, 32'hC000_0001, 32'h3380_0000
  };

  initial begin
    start            <= 1'b0;
    rst_n            <= 1'b0;
    in_value_bits    <= '0;
    in_int_width     <= '0;
    in_frac_width    <= '0;
    in_signed_format <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: special patterns across empty, full and mid formats, both signs.
    foreach (directed_vals[i]) begin
      send_request(directed_vals[i], 4'(i % 3 == 0 ? 0 : (i % 3 == 1 ? 15 : 7)),
                   4'(i % 4 == 0 ? 0 : (i % 4 == 1 ? 15 : 4)), 1'(i % 2), rand_gap());
    end
    send_request(32'hBF80_0000, 4'd0, 4'd0, 1'b1, 1);

    // Hold off until every expected result has come back.
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);

    for (int i = 0; i < NumRandom; i++) begin
      send_request(rand_float(), 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)), rand_gap());
    end
    start <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (DrainWait) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/ffc_pkg.sv
hw/rtl/float_to_fixed_format_convert_top.sv
dv/float_to_fixed_format_convert_checker.sv
dv/float_to_fixed_format_convert_top_test.sv
